// File: rtl/xxbc_pkg.sv
// ----------------------------------------------------------------------------
// xxbc_pkg
// Shared types, constants and the round-count table for the byte-element
// XXTEA cipher unit.
// ----------------------------------------------------------------------------
package xxbc_pkg;

  // block store geometry
  localparam int MAX_BLOCK_BYTES = 64;
  localparam int ADDR_W          = $clog2(MAX_BLOCK_BYTES);
  localparam int LEN_W           = ADDR_W + 1;
  localparam int ROUND_W         = 6;

  // only the low byte of the 32-bit mix reaches an element, and the low byte
  // of a 32-bit sum depends only on the low bytes of its operands
  localparam logic [7:0] DELTA_LO = 8'hB9;

  // low key bytes after reset
  localparam logic [7:0] KEY0_RST = 8'hE8;
  localparam logic [7:0] KEY1_RST = 8'h7D;
  localparam logic [7:0] KEY2_RST = 8'h42;
  localparam logic [7:0] KEY3_RST = 8'h1A;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_KEY0 = 3'd0,
    CFG_KEY1 = 3'd1,
    CFG_KEY2 = 3'd2,
    CFG_KEY3 = 3'd3,
    CFG_DIR  = 3'd4
  } cfg_index_t;

  // operands of one element update
  typedef struct packed {
    logic [7:0] cur;
    logic [7:0] z;
    logic [7:0] y;
    logic [7:0] sum;
    logic [7:0] key;
    logic       dec;
  } mix_req_t;

  // rounds for a block of n bytes: 6 + 52 / n
  function automatic logic [ROUND_W-1:0] rounds_for(input logic [LEN_W-1:0] n);
    logic [ROUND_W-1:0] r;
    case (n) inside
      7'd2:        r = 6'd32;
      7'd3:        r = 6'd23;
      7'd4:        r = 6'd19;
      7'd5:        r = 6'd16;
      7'd6:        r = 6'd14;
      7'd7:        r = 6'd13;
      7'd8:        r = 6'd12;
      [7'd9:7'd10]:  r = 6'd11;
      [7'd11:7'd13]: r = 6'd10;
      [7'd14:7'd17]: r = 6'd9;
      [7'd18:7'd26]: r = 6'd8;
      [7'd27:7'd52]: r = 6'd7;
      default:     r = 6'd6;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/xxbc_mix.sv
// ----------------------------------------------------------------------------
// xxbc_mix
// One XXTEA element update on bytes: low byte of the mix function, added
// to the element for encryption or subtracted for decryption.
// ----------------------------------------------------------------------------
module xxbc_mix (
  input  xxbc_pkg::mix_req_t req,
  output logic [7:0]         result
);

  logic [7:0] a_sum;
  logic [7:0] b_sum;
  logic [7:0] mix_lo;

  // (z>>5 ^ y<<2) + (y>>3 ^ z<<4), low byte only
  assign a_sum = ({3'b000, req.z[7:5]} ^ {req.y[5:0], 2'b00}) +
                 ({3'b000, req.y[7:3]} ^ {req.z[3:0], 4'b0000});

  // (sum ^ y) + (k ^ z), low byte only
  assign b_sum = (req.sum ^ req.y) + (req.key ^ req.z);

  assign mix_lo = a_sum ^ b_sum;

  // apply to element
  assign result = req.dec ? (req.cur - mix_lo) : (req.cur + mix_lo);

endmodule

// File: rtl/xxtea_byte_block_cipher_unit.sv
// An n-byte block (2..64) runs (6 + 52/n) rounds of n element updates after its
//   closing beat; the store's single read port splits each update into a read state
//   and an update state. One input beat is taken per cycle while loading, if the
//   output is free; results drain through alternating emit read and data states.
// A one-byte block passes through the output register in the cycle after its beat.
// Reset (sync, rst_n low) clears control, restores key and direction; store uncleared.
// ----------------------------------------------------------------------------
// xxtea_byte_block_cipher_unit
// Collects a block of bytes, runs byte-element XXTEA in place in a block
// store and streams the transformed block out.
// ----------------------------------------------------------------------------
module xxtea_byte_block_cipher_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data,
  input  logic        in_last,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data,
  output logic        out_last,
  output logic        out_short_block
);

  localparam int AW = xxbc_pkg::ADDR_W;
  localparam int LW = xxbc_pkg::LEN_W;
  localparam int RW = xxbc_pkg::ROUND_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(xxbc_pkg::MAX_BLOCK_BYTES - 1);

  typedef enum logic [4:0] {
    ST_LOAD     = 5'b00001,
    ST_RD       = 5'b00010,
    ST_UPD      = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_DAT = 5'b10000
  } state_t;

  // control and datapath registers
  state_t        state_r, state_nxt;
  logic [AW-1:0] count_r, count_nxt;
  logic [AW-1:0] last_idx_r, last_idx_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [RW-1:0] rounds_r, rounds_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    cur_r, cur_nxt;
  logic [7:0]    link_r, link_nxt;
  logic [7:0]    first_r, first_nxt;
  logic          dir_r, dir_nxt;
  logic [7:0]    key_r [4];
  logic          dir_cfg_r;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_short_r, out_short_nxt;
  logic          out_valid_r, out_valid_nxt;

  // block store
  logic [7:0]    mem [xxbc_pkg::MAX_BLOCK_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    rdata_r;

  // misc
  logic               in_fire;
  logic               out_free;
  logic               closing;
  logic [LW-1:0]      blk_len;
  logic [RW-1:0]      blk_rounds;
  logic [7:0]         dec_sum_init;
  logic               round_end;
  xxbc_pkg::mix_req_t mreq;
  logic [7:0]         upd_byte;

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_LOAD) && out_free;
  assign in_fire    = in_valid && in_ready;
  assign closing    = in_last || (count_r == LAST_ADDR);
  assign blk_len    = {1'b0, count_r} + LW'(1);
  assign blk_rounds = xxbc_pkg::rounds_for(blk_len);
  assign dec_sum_init = 8'({2'b00, blk_rounds} * xxbc_pkg::DELTA_LO);
  assign round_end  = dir_r ? (pos_r == '0) : (pos_r == last_idx_r);

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign out_last        = out_last_r;
  assign out_short_block = out_short_r;

  // update operands: read data is y when encrypting, z when decrypting
  always_comb begin
    mreq.cur = cur_r;
    mreq.z   = dir_r ? rdata_r : link_r;
    mreq.y   = dir_r ? link_r : rdata_r;
    mreq.sum = sum_r;
    mreq.key = key_r[pos_r[1:0] ^ sum_r[3:2]];
    mreq.dec = dir_r;
  end

  xxbc_mix u_mix (
    .req    (mreq),
    .result (upd_byte)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    last_idx_nxt  = last_idx_r;
    pos_nxt       = pos_r;
    rounds_nxt    = rounds_r;
    sum_nxt       = sum_r;
    cur_nxt       = cur_r;
    link_nxt      = link_r;
    first_nxt     = first_r;
    dir_nxt       = dir_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_short_nxt = out_short_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = count_r;
    mem_wdata     = in_data;
    mem_raddr     = pos_r;

    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          mem_we = 1'b1;
          if (count_r == '0) begin
            first_nxt = in_data;
          end
          if (!closing) begin
            count_nxt = count_r + AW'(1);
          end else if (count_r == '0) begin
            // one-byte block goes straight out
            out_data_nxt  = in_data;
            out_last_nxt  = 1'b1;
            out_short_nxt = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            count_nxt    = '0;
            last_idx_nxt = count_r;
            rounds_nxt   = blk_rounds;
            dir_nxt      = dir_cfg_r;
            if (dir_cfg_r) begin
              sum_nxt  = dec_sum_init;
              link_nxt = first_r;
              cur_nxt  = in_data;
              pos_nxt  = count_r;
            end else begin
              sum_nxt  = xxbc_pkg::DELTA_LO;
              link_nxt = in_data;
              cur_nxt  = first_r;
              pos_nxt  = '0;
            end
            state_nxt = ST_RD;
          end
        end
      end

      ST_RD: begin
        // fetch the neighbor element
        if (dir_r) begin
          mem_raddr = (pos_r == '0) ? last_idx_r : pos_r - AW'(1);
        end else begin
          mem_raddr = (pos_r == last_idx_r) ? '0 : pos_r + AW'(1);
        end
        state_nxt = ST_UPD;
      end

      ST_UPD: begin
        // write back the updated element
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = upd_byte;
        link_nxt  = upd_byte;
        cur_nxt   = rdata_r;
        state_nxt = ST_RD;
        if (!round_end) begin
          pos_nxt = dir_r ? pos_r - AW'(1) : pos_r + AW'(1);
        end else if (rounds_r == RW'(1)) begin
          rounds_nxt = '0;
          pos_nxt    = '0;
          state_nxt  = ST_EMIT_RD;
        end else begin
          rounds_nxt = rounds_r - RW'(1);
          if (dir_r) begin
            sum_nxt = sum_r - xxbc_pkg::DELTA_LO;
            pos_nxt = last_idx_r;
          end else begin
            sum_nxt = sum_r + xxbc_pkg::DELTA_LO;
            pos_nxt = '0;
          end
        end
      end

      ST_EMIT_RD: begin
        mem_raddr = pos_r;
        if (out_free) begin
          state_nxt = ST_EMIT_DAT;
        end
      end

      ST_EMIT_DAT: begin
        out_data_nxt  = rdata_r;
        out_last_nxt  = (pos_r == last_idx_r);
        out_short_nxt = 1'b0;
        out_valid_nxt = 1'b1;
        if (pos_r == last_idx_r) begin
          state_nxt = ST_LOAD;
        end else begin
          pos_nxt   = pos_r + AW'(1);
          state_nxt = ST_EMIT_RD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      rounds_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rounds_r    <= rounds_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    last_idx_r  <= last_idx_nxt;
    pos_r       <= pos_nxt;
    sum_r       <= sum_nxt;
    cur_r       <= cur_nxt;
    link_r      <= link_nxt;
    first_r     <= first_nxt;
    dir_r       <= dir_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    out_short_r <= out_short_nxt;
  end

  // configuration registers; only the low key byte reaches an element
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]  <= xxbc_pkg::KEY0_RST;
      key_r[1]  <= xxbc_pkg::KEY1_RST;
      key_r[2]  <= xxbc_pkg::KEY2_RST;
      key_r[3]  <= xxbc_pkg::KEY3_RST;
      dir_cfg_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        xxbc_pkg::CFG_KEY0: key_r[0]  <= cfg_data[7:0];
        xxbc_pkg::CFG_KEY1: key_r[1]  <= cfg_data[7:0];
        xxbc_pkg::CFG_KEY2: key_r[2]  <= cfg_data[7:0];
        xxbc_pkg::CFG_KEY3: key_r[3]  <= cfg_data[7:0];
        xxbc_pkg::CFG_DIR:  dir_cfg_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // block store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // an update always follows the read of its neighbor
  a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> $past(state_r) == ST_RD)
    else $error("update without neighbor read");

  // rounds remain while the cipher loop runs
  a_rounds_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD || state_r == ST_UPD) |-> rounds_r != '0)
    else $error("cipher loop running with no rounds left");

  // a one-byte result is always the last of its block
  a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_short_r |-> out_last_r)
    else $error("short block beat not marked last");

  // closing a block leaves the fill count empty
  a_close_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == ST_LOAD && state_r == ST_RD |-> count_r == '0)
    else $error("fill count not cleared at block close");

  // position stays within the block while working on it
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> pos_r <= last_idx_r)
    else $error("element position outside block");

endmodule
